// ----- rtl/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the timed step-move controller.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int unsigned POS_W = 32;
	localparam int unsigned IV_W = 16;
	localparam int unsigned RUN_W = 47;
	localparam int unsigned LATE_W = 49;
	localparam logic [IV_W-1:0] IV_RESET = 16'd1000;

	typedef enum logic [1:0] {
		CMD_REL  = 2'd0,
		CMD_ABS  = 2'd1,
		CMD_DONE = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_LATE,
		S_CHECK,
		S_DIV,
		S_FINISH,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic reject;
		logic start_move;
		logic clear_err;
		logic estop;
		logic mul;
		logic late;
		logic div_start;
		logic finish;
		logic load_out;
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic moving;
		logic steps_zero;
		logic pending_nz;
		logic late_gt;
		logic div_done;
	} dp_stat_t;

endpackage

// ----- rtl/tsm_req_if.sv -----
// ----------------------------------------------------------------------------
// tsm_req_if
// Command channel: one word per move, timer-done or stop event.
// ----------------------------------------------------------------------------
interface tsm_req_if import tsm_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t command;
	logic signed [POS_W-1:0] amount;
	logic [31:0] now_us;

	modport source (output valid, command, amount, now_us, input ready);
	modport sink (input valid, command, amount, now_us, output ready);
endinterface

// ----- rtl/tsm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tsm_rsp_if
// Result channel: one word per accepted command word.
// ----------------------------------------------------------------------------
interface tsm_rsp_if import tsm_pkg::*; ();
	logic valid;
	logic ready;
	logic status;
	logic busy_res;
	logic drive_enable;
	logic direction_forward;
	logic [RUN_W-1:0] run_time_us;
	logic signed [POS_W-1:0] position;
	logic signed [POS_W-1:0] step_error;
	logic move_done;

	modport source (output valid, status, busy_res, drive_enable, direction_forward,
		run_time_us, position, step_error, move_done, input ready);
	modport sink (input valid, status, busy_res, drive_enable, direction_forward,
		run_time_us, position, step_error, move_done, output ready);
endinterface

// ----- rtl/timed_step_move_with_lateness_fix_top.sv -----
// ----------------------------------------------------------------------------
// timed_step_move_with_lateness_fix_top
// Open-loop step-move controller with late-completion step correction.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one word per event: a relative or absolute
// move, a timer-done event or an emergency stop, each with its time stamp.
// For every accepted word exactly one word leaves on the rsp channel, giving
// the accept/reject status, the drive outputs, the run time for the external
// timer, the believed position, the step error and a move-done pulse.
// The step interval is written through cfg_we and cfg_data; the user must
// do so only while idle, the block itself does not enforce it. A started move
// passes decode and the run-time multiply; a stop or a rejected move goes
// straight to the result; a completion passes the lateness check and, if a
// correction is due, the divider, one quotient bit per cycle over 32 bits.
// The block works on one word at a time: req.ready is high only while the
// controller is idle, so the next word can be taken once the previous result
// is registered, even if that result is still waiting on rsp. When the
// receiver stalls, the result stays in the output register and the next
// word's result waits in the controller until the register is free.
// Reset clears position, error, motion state and the handshakes, and sets
// the step interval to 1000 microseconds.
// ----------------------------------------------------------------------------
module timed_step_move_with_lateness_fix_top import tsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IV_W-1:0]  cfg_data,
	tsm_req_if.sink          req,
	tsm_rsp_if.source        rsp
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	// The controller decides what each word does; the datapath holds the
	// motion state and does all arithmetic on the controller's commands.
	tsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	tsm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.command           (req.command),
		.amount            (req.amount),
		.now_us            (req.now_us),
		.ctrl              (ctrl),
		.stat              (stat),
		.status            (rsp.status),
		.busy_res          (rsp.busy_res),
		.drive_enable      (rsp.drive_enable),
		.direction_forward (rsp.direction_forward),
		.run_time_us       (rsp.run_time_us),
		.position          (rsp.position),
		.step_error        (rsp.step_error),
		.move_done         (rsp.move_done)
	);

	// Only one word is in flight, so an accepted word closes the request side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while a word was in flight");

	// A completed move always leaves the drive off and the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.move_done) |-> (!rsp.busy_res && !rsp.drive_enable))
		else $error("move completion left drive or busy set");

	// A rejected move reports no run time and leaves the block busy.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (rsp.busy_res && (rsp.run_time_us == '0)))
		else $error("rejected move with run time or idle state");

	// A reported run time belongs to a move that has just started.
	a_run_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.run_time_us != '0)) |->
		(rsp.busy_res && rsp.drive_enable && !rsp.move_done))
		else $error("run time reported without a started move");

endmodule

// ----- rtl/tsm_div.sv -----
// ----------------------------------------------------------------------------
// tsm_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// ----------------------------------------------------------------------------
module tsm_div import tsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	input  logic [IV_W-1:0]   divisor,
	output logic              done,
	output logic [31:0]       quotient
);

	logic            busy_q;
	logic [4:0]      cnt_q;
	logic [IV_W-1:0] rem_q;
	logic [IV_W-1:0] dsr_q;
	logic [31:0]     dvd_q;
	logic [IV_W:0]   trial;
	logic [IV_W:0]   shifted;

	assign shifted = {rem_q, dvd_q[31]};
	assign trial = shifted - {1'b0, dsr_q};
	assign done = busy_q && (cnt_q == 5'd0);
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			// A set top bit of the trial means the divisor did not fit.
			if (trial[IV_W]) begin
				rem_q <= shifted[IV_W-1:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
			end else begin
				rem_q <= trial[IV_W-1:0];
				dvd_q <= {dvd_q[30:0], 1'b1};
			end
		end
	end

endmodule

// ----- rtl/tsm_dp.sv -----
// ----------------------------------------------------------------------------
// tsm_dp
// Datapath: move state, interval register, run-time multiply, lateness
// check and correction, result register.
// ----------------------------------------------------------------------------
module tsm_dp import tsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IV_W-1:0]          cfg_data,
	input  cmd_t                     command,
	input  logic signed [POS_W-1:0]  amount,
	input  logic [31:0]              now_us,
	input  dp_ctrl_t                 ctrl,
	output dp_stat_t                 stat,
	output logic                     status,
	output logic                     busy_res,
	output logic                     drive_enable,
	output logic                     direction_forward,
	output logic [RUN_W-1:0]         run_time_us,
	output logic signed [POS_W-1:0]  position,
	output logic signed [POS_W-1:0]  step_error,
	output logic                     move_done
);

	logic [IV_W-1:0]   interval_q;
	logic              moving_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pending_q;
	logic [POS_W-1:0]  err_q;
	logic [31:0]       start_q;
	logic [RUN_W-1:0]  planned_q;
	logic              drive_q;
	logic              heading_q;

	cmd_t              cmd_q;
	logic [POS_W-1:0]  amount_q;
	logic [31:0]       now_q;
	logic              status_q;
	logic              done_q;
	logic [RUN_W-1:0]  run_q;
	logic [POS_W-1:0]  mag_q;
	logic [LATE_W-1:0] late_q;
	logic              fix_en_q;

	logic [IV_W-1:0]   iv_eff;
	logic [POS_W-1:0]  steps;
	logic [47:0]       product;
	logic [31:0]       elapsed;
	logic [LATE_W-1:0] late;
	logic [31:0]       quotient;
	logic [31:0]       fix;
	logic              div_done;

	// An interval of zero counts as one.
	assign iv_eff = (interval_q == '0) ? IV_W'(1) : interval_q;
	assign steps = ((cmd_q == CMD_REL) ? amount_q : (amount_q - pos_q)) - err_q;
	assign product = {32'd0, iv_eff} * {16'd0, mag_q};
	assign elapsed = now_q - start_q;
	assign late = {17'd0, elapsed} - {2'd0, planned_q};
	assign fix = quotient + 32'd1;

	assign stat.cmd = cmd_q;
	assign stat.moving = moving_q;
	assign stat.steps_zero = (steps == '0);
	assign stat.pending_nz = (pending_q != '0);
	assign stat.late_gt = $signed(late_q) > $signed({34'd0, iv_eff[IV_W-1:1]});
	assign stat.div_done = div_done;

	tsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (late_q[31:0]),
		.divisor  (iv_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IV_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q <= 1'b0;
			pos_q <= '0;
			pending_q <= '0;
			err_q <= '0;
			start_q <= '0;
			planned_q <= '0;
			drive_q <= 1'b0;
			heading_q <= 1'b0;
		end else begin
			if (ctrl.start_move) begin
				start_q <= now_q;
				moving_q <= 1'b1;
				pending_q <= steps;
				heading_q <= !steps[POS_W-1];
				drive_q <= 1'b1;
				err_q <= '0;
			end
			if (ctrl.clear_err) begin
				err_q <= '0;
			end
			if (ctrl.estop) begin
				drive_q <= 1'b0;
				moving_q <= 1'b0;
			end
			if (ctrl.mul) begin
				planned_q <= product[RUN_W-1:0];
			end
			if (ctrl.finish) begin
				drive_q <= 1'b0;
				moving_q <= 1'b0;
				pos_q <= pos_q + pending_q;
				pending_q <= '0;
				if (fix_en_q) begin
					err_q <= pending_q[POS_W-1] ? (err_q - fix) : (err_q + fix);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= command;
			amount_q <= amount;
			now_q <= now_us;
			status_q <= 1'b0;
			done_q <= 1'b0;
			run_q <= '0;
		end
		if (ctrl.reject) begin
			status_q <= 1'b1;
		end
		if (ctrl.start_move) begin
			mag_q <= steps[POS_W-1] ? (POS_W'(0) - steps) : steps;
		end
		if (ctrl.mul) begin
			run_q <= product[RUN_W-1:0];
		end
		if (ctrl.late) begin
			late_q <= late;
			fix_en_q <= 1'b0;
		end
		if (ctrl.div_start) begin
			fix_en_q <= 1'b1;
		end
		if (ctrl.finish) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			status <= status_q;
			busy_res <= moving_q;
			drive_enable <= drive_q;
			direction_forward <= heading_q;
			run_time_us <= run_q;
			position <= pos_q;
			step_error <= err_q;
			move_done <= done_q;
		end
	end

endmodule

// ----- rtl/tsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsm_ctrl
// Controller: sequences one command word through the datapath and owns
// the channel handshakes.
// ----------------------------------------------------------------------------
module tsm_ctrl import tsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctrl.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_REL, CMD_ABS: begin
						if (stat.moving) begin
							ctrl.reject = 1'b1;
							state_d = S_OUT;
						end else if (stat.steps_zero) begin
							ctrl.clear_err = 1'b1;
							state_d = S_LATE;
						end else begin
							ctrl.start_move = 1'b1;
							state_d = S_MUL;
						end
					end
					CMD_DONE: begin
						state_d = stat.moving ? S_LATE : S_OUT;
					end
					CMD_STOP: begin
						ctrl.estop = 1'b1;
						state_d = S_OUT;
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_MUL: begin
				ctrl.mul = 1'b1;
				state_d = S_OUT;
			end
			S_LATE: begin
				ctrl.late = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.pending_nz && stat.late_gt) begin
					ctrl.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				ctrl.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctrl.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
